// ===== hw/rtl/mmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants of the min-max normaliser: word layouts of the
// sample and result channels and the widths of the serial divider.
// ----------------------------------------------------------------------------
package mmn_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int Q_FRAC    = 16;
    localparam int Q_W       = Q_FRAC + 1;
    // one integer quotient bit, then one bit per fraction position
    localparam int DIV_STEPS = Q_FRAC + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       is_last;
    } sample_t;

    typedef struct packed {
        logic [Q_W-1:0] normalised_value;
        logic           divide_by_zero;
        logic           overflow_dropped;
        logic           last_result;
    } result_t;

endpackage

// ===== hw/rtl/mmn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mmn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mmn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_div
// Bit-serial restoring divider: one quotient bit per cycle, giving
// (x << Q_FRAC) / divisor for x <= divisor as an unsigned Q1.16 value.
// ----------------------------------------------------------------------------
module mmn_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mmn_pkg::SAMPLE_W-1:0] x,
    input  logic [mmn_pkg::SAMPLE_W-1:0] divisor,
    output logic                         done,
    output logic [mmn_pkg::Q_W-1:0]      quotient
);
    import mmn_pkg::*;

    logic [SAMPLE_W:0]   rem_reg, rem_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W+1:0] diff;
    logic                ge;
    logic [SAMPLE_W:0]   rem_sel;

    assign diff    = {1'b0, rem_reg} - {2'b00, divisor};
    assign ge      = ~diff[SAMPLE_W+1];
    assign rem_sel = ge ? diff[SAMPLE_W:0] : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, x};
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the shift never loses a bit
            rem_next = {rem_sel[SAMPLE_W-1:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], ge};
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hw/rtl/min_max_normaliser.sv =====
`timescale 1ns / 1ps
// Load: one sample word per cycle; sample_stall stays low until the last word of a set.
// After the last word: results follow one sample at a time, each through ram read,
// operand, 17 steps of the bit-serial divider and output load (held while result_stall).
// Reset: rst_n asynchronous, active low; clears the set and the handshakes,
// sample ram contents are kept and only entries written in the current set are read.
// ----------------------------------------------------------------------------
// min_max_normaliser
// Buffers a set of signed samples, tracks their min and max, and on the last
// word emits every buffered sample scaled into [0, 1] as unsigned Q1.16.
// ----------------------------------------------------------------------------
module min_max_normaliser #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  mmn_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output mmn_pkg::result_t  result
);
    import mmn_pkg::*;

    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_PUSH  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                       ovf_reg, ovf_next;
    logic signed [SAMPLE_W-1:0] offset_reg, offset_next;
    logic [SAMPLE_W-1:0]        divisor_reg, divisor_next;
    logic                       dz_reg, dz_next;
    logic                       result_valid_reg, result_valid_next;
    result_t                    result_reg, result_next;

    logic                       accept;
    logic                       ram_we;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] off_sel;
    logic [SAMPLE_W:0]          span;
    logic [SAMPLE_W:0]          shifted;
    logic [SAMPLE_W-1:0]        div_x;
    logic                       div_start;
    logic                       div_done;
    logic [Q_W-1:0]             div_q;
    logic                       k_last;

    assign accept = sample_valid && (state_reg == ST_LOAD);
    assign ram_we = accept && (count_reg != CNT_W'(BUFFER_DEPTH));

    mmn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sample.sample_value),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // offset is the minimum only when it is negative
    assign off_sel = min_reg[SAMPLE_W-1] ? min_reg : '0;
    assign span    = {max_reg[SAMPLE_W-1], max_reg} - {off_sel[SAMPLE_W-1], off_sel};
    assign shifted = {ram_rdata[SAMPLE_W-1], ram_rdata}
                   - {offset_reg[SAMPLE_W-1], offset_reg};
    assign div_x   = shifted[SAMPLE_W] ? '0 : shifted[SAMPLE_W-1:0];

    assign div_start = (state_reg == ST_START);

    mmn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .x        (div_x),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign k_last = (CNT_W'(k_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        k_next            = k_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        ovf_next          = ovf_reg;
        offset_next       = offset_reg;
        divisor_next      = divisor_reg;
        dz_next           = dz_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (ram_we)
                    begin
                        if (count_reg == '0)
                        begin
                            min_next = sample.sample_value;
                            max_next = sample.sample_value;
                        end
                        else
                        begin
                            if (sample.sample_value < min_reg)
                            begin
                                min_next = sample.sample_value;
                            end
                            if (sample.sample_value > max_reg)
                            begin
                                max_next = sample.sample_value;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (sample.is_last)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                offset_next  = off_sel;
                divisor_next = span[SAMPLE_W-1:0];
                dz_next      = (span[SAMPLE_W-1:0] == '0);
                k_next       = '0;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next            = 1'b1;
                    result_next.normalised_value = dz_reg ? '0 : div_q;
                    result_next.divide_by_zero   = dz_reg;
                    result_next.overflow_dropped = ovf_reg;
                    result_next.last_result      = k_last;
                    if (k_last)
                    begin
                        // set done, start over empty
                        count_next = '0;
                        k_next     = '0;
                        min_next   = '0;
                        max_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            k_reg            <= '0;
            min_reg          <= '0;
            max_reg          <= '0;
            ovf_reg          <= 1'b0;
            dz_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            k_reg            <= k_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            ovf_reg          <= ovf_next;
            dz_reg           <= dz_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg  <= offset_next;
        divisor_reg <= divisor_next;
        result_reg  <= result_next;
    end

    assign sample_stall = (state_reg != ST_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/mmn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_checker
// Port-level checks of the min-max normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module mmn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input mmn_pkg::sample_t  sample,
    input logic              result_valid,
    input logic              result_stall,
    input mmn_pkg::result_t  result
);
    import mmn_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // the last sample word of a set stops further loading while results are built
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample.is_last |=> sample_stall)
        else $error("sample taken right after last word");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_by_zero |-> result.normalised_value == '0)
        else $error("zero divisor with nonzero value");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.normalised_value <= Q_W'(1 << Q_FRAC))
        else $error("normalised value above one");

endmodule

bind min_max_normaliser mmn_checker u_mmn_checker (.*);
